// File: hw/rtl/twqs_pkg.sv
// Shared types and constants of the thread wait queue scheduler.
package twqs_pkg;
	localparam int Threads = 16;
	localparam int WaitQueues = 8;
	localparam int TW = 4;
	localparam int QW = 4;
	localparam int CW = 5;
	localparam int NQ = WaitQueues + 1;
	localparam logic [QW-1:0] RUNQ = QW'(WaitQueues);
	localparam logic [QW-1:0] QNONE = 4'd15;

	localparam logic [2:0] A_MKRUN = 3'd0;
	localparam logic [2:0] A_SLEEP = 3'd1;
	localparam logic [2:0] A_CSLEEP = 3'd2;
	localparam logic [2:0] A_WAKE = 3'd3;
	localparam logic [2:0] A_BCAST = 3'd4;
	localparam logic [2:0] A_CANCEL = 3'd5;
	localparam logic [2:0] A_YIELD = 3'd6;
	localparam logic [2:0] A_EXIT = 3'd7;

	localparam logic [2:0] S_OK = 3'd0;
	localparam logic [2:0] S_INTR = 3'd1;
	localparam logic [2:0] S_IDLE = 3'd2;
	localparam logic [2:0] S_EMPTY = 3'd3;
	localparam logic [2:0] S_QUEUED = 3'd4;

	localparam logic [1:0] M_NONE = 2'd0;
	localparam logic [1:0] M_RUN = 2'd1;
	localparam logic [1:0] M_SLEEP = 2'd2;
	localparam logic [1:0] M_CSLP = 2'd3;

	typedef struct packed {
		logic start;
		logic step;
		logic sw;
		logic emit_last;
	} cmd_t;

	typedef struct packed {
		logic need_switch;
		logic bcast_more;
		logic single;
	} sts_t;
endpackage

// File: hw/rtl/thread_wait_queue_scheduler_core.sv
// Top level of the thread wait queue scheduler core.
// Thread scheduler with a FIFO run queue and eight FIFO wait queues of
// sixteen threads, kept as doubly linked lists in per-thread link tables.
// One action word is taken at a time: it is latched and executed, followed
// by a run queue switch step where the action switches threads,
// and its result word is held until taken. Broadcast gives one result word
// per woken thread; the next queue entry is walked only once the previous word is taken.
module thread_wait_queue_scheduler_core import twqs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [2:0] action,
	input  logic [3:0] thread_id,
	input  logic [2:0] queue_id,
	output logic out_valid,
	input  logic out_ready,
	output logic [2:0] status,
	output logic [3:0] woken_thread,
	output logic woken_valid,
	output logic [3:0] current_thread,
	output logic current_valid,
	output logic current_cancelled,
	output logic last
);
	cmd_t cmd;
	sts_t sts;

	twqs_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.sts, .cmd
	);

	twqs_dp u_dp (
		.clk, .arst_n, .action, .thread_id, .queue_id, .cmd, .sts,
		.status, .woken_thread, .woken_valid, .current_thread,
		.current_valid, .current_cancelled, .last
	);

	// A new word is never taken while a result is pending.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	// A woken word always carries ok status.
	a_wok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && woken_valid) |-> status == S_OK) else $error("woken bad status");
	// No current thread implies no cancelled flag shown.
	a_cur: assert property (@(posedge clk) disable iff (!arst_n)
		!current_valid |-> !current_cancelled) else $error("cancel w/o thread");
endmodule

// File: hw/rtl/twqs_ctrl.sv
// Sequencer of the thread wait queue scheduler.
module twqs_ctrl import twqs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EXEC = 5'b00010,
		ST_SW = 5'b00100,
		ST_BC = 5'b01000,
		ST_OUT = 5'b10000
	} state_t;
	state_t state_q;
	logic more_q;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		cmd = '0;
		cmd.start = in_valid && in_ready;
		unique case (state_q)
			ST_EXEC: begin
				cmd.emit_last = 1'b1;
			end
			ST_SW: begin
				cmd.sw = 1'b1;
				cmd.emit_last = 1'b1;
			end
			ST_BC: begin
				cmd.step = 1'b1;
				cmd.emit_last = !sts.bcast_more;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			more_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (cmd.start) state_q <= ST_EXEC;
				ST_EXEC: begin
					if (sts.need_switch) state_q <= ST_SW;
					else if (sts.single) state_q <= ST_OUT;
					else state_q <= ST_BC;
					more_q <= 1'b0;
				end
				ST_SW: state_q <= ST_OUT;
				ST_BC: begin
					more_q <= sts.bcast_more;
					state_q <= ST_OUT;
				end
				ST_OUT: if (out_ready) state_q <= more_q ? ST_BC : ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: hw/rtl/twqs_dp.sv
// Datapath of the scheduler: thread tables, queue tables, result register.
module twqs_dp import twqs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic [2:0] action,
	input  logic [TW-1:0] thread_id,
	input  logic [2:0] queue_id,
	input  cmd_t cmd,
	output sts_t sts,
	output logic [2:0] status,
	output logic [TW-1:0] woken_thread,
	output logic woken_valid,
	output logic [TW-1:0] current_thread,
	output logic current_valid,
	output logic current_cancelled,
	output logic last
);
	logic [1:0] mode_q [Threads];
	logic cflag_q [Threads];
	logic [QW-1:0] qon_q [Threads];
	logic [TW-1:0] nxt_q [Threads];
	logic [TW-1:0] prv_q [Threads];
	logic [TW-1:0] head_q [NQ];
	logic [TW-1:0] tail_q [NQ];
	logic [CW-1:0] cnt_q [NQ];
	logic [TW-1:0] run_q;
	logic runv_q;
	logic [2:0] act_q;
	logic [TW-1:0] tid_q;
	logic [QW-1:0] qid_q;
	logic [2:0] st_q;
	logic [TW-1:0] wk_q;
	logic wkv_q;
	logic last_q;
	logic [TW-1:0] bcn_q;

	// Action phase decisions, from latched word.
	logic [QW-1:0] qa;
	logic early;
	logic [2:0] est;
	logic ewv;
	always_comb begin
		qa = qid_q;
		early = 1'b0;
		est = S_OK;
		ewv = 1'b0;
		unique case (act_q)
			A_MKRUN: begin
				early = 1'b1;
				est = (qon_q[tid_q] != QNONE) ? S_QUEUED : S_OK;
			end
			A_SLEEP, A_CSLEEP: begin
				if (runv_q && act_q == A_CSLEEP && cflag_q[run_q]) begin
					early = 1'b1;
					est = S_INTR;
				end else if (runv_q && qon_q[run_q] != QNONE) begin
					early = 1'b1;
					est = S_QUEUED;
				end
			end
			A_WAKE: begin
				early = 1'b1;
				est = (cnt_q[qa] == '0) ? S_EMPTY : S_OK;
				ewv = (cnt_q[qa] != '0);
			end
			A_BCAST: begin
				early = (cnt_q[qa] == '0);
				est = S_EMPTY;
			end
			A_CANCEL: begin
				early = 1'b1;
				ewv = (mode_q[tid_q] == M_CSLP) && (qon_q[tid_q] < QW'(WaitQueues));
			end
			default: ;
		endcase
	end
	assign sts.need_switch = !early && (act_q != A_BCAST);
	assign sts.single = early;
	assign sts.bcast_more = (cnt_q[qa] > CW'(1)) && (bcn_q != TW'(Threads - 1));

	logic do_exec_q;
	// Switch decision
	logic push_cur;
	assign push_cur = runv_q && mode_q[run_q] == M_RUN && qon_q[run_q] == QNONE;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			act_q <= action;
			tid_q <= thread_id;
			qid_q <= {1'b0, queue_id};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Threads; i++) begin
				mode_q[i] <= M_NONE;
				cflag_q[i] <= 1'b0;
				qon_q[i] <= QNONE;
			end
			for (int i = 0; i < NQ; i++) cnt_q[i] <= '0;
			run_q <= '0;
			runv_q <= 1'b0;
			do_exec_q <= 1'b0;
			bcn_q <= '0;
		end else begin
			do_exec_q <= cmd.start;
			if (cmd.start) bcn_q <= '0;
			if (do_exec_q) begin
				unique case (act_q)
					A_MKRUN: if (qon_q[tid_q] == QNONE) begin
						if (mode_q[tid_q] == M_NONE) cflag_q[tid_q] <= 1'b0;
						mode_q[tid_q] <= M_RUN;
						if (cnt_q[RUNQ] != '0) begin
							nxt_q[tail_q[RUNQ]] <= tid_q;
							prv_q[tid_q] <= tail_q[RUNQ];
						end else head_q[RUNQ] <= tid_q;
						tail_q[RUNQ] <= tid_q;
						cnt_q[RUNQ] <= cnt_q[RUNQ] + CW'(1);
						qon_q[tid_q] <= RUNQ;
					end
					A_SLEEP, A_CSLEEP: if (!early && runv_q) begin
						mode_q[run_q] <= (act_q == A_CSLEEP) ? M_CSLP : M_SLEEP;
						if (cnt_q[qa] != '0) begin
							nxt_q[tail_q[qa]] <= run_q;
							prv_q[run_q] <= tail_q[qa];
						end else head_q[qa] <= run_q;
						tail_q[qa] <= run_q;
						cnt_q[qa] <= cnt_q[qa] + CW'(1);
						qon_q[run_q] <= qa;
					end
					A_WAKE: if (cnt_q[qa] != '0) begin
						wk_q <= head_q[qa];
						if (cnt_q[qa] > CW'(1)) head_q[qa] <= nxt_q[head_q[qa]];
						cnt_q[qa] <= cnt_q[qa] - CW'(1);
						mode_q[head_q[qa]] <= M_RUN;
						if (cnt_q[RUNQ] != '0) begin
							nxt_q[tail_q[RUNQ]] <= head_q[qa];
							prv_q[head_q[qa]] <= tail_q[RUNQ];
						end else head_q[RUNQ] <= head_q[qa];
						tail_q[RUNQ] <= head_q[qa];
						cnt_q[RUNQ] <= cnt_q[RUNQ] + CW'(1);
						qon_q[head_q[qa]] <= RUNQ;
					end
					A_CANCEL: begin
						cflag_q[tid_q] <= 1'b1;
						if (ewv) begin
							wk_q <= tid_q;
							if (head_q[qon_q[tid_q]] == tid_q)
								head_q[qon_q[tid_q]] <= nxt_q[tid_q];
							else nxt_q[prv_q[tid_q]] <= nxt_q[tid_q];
							if (tail_q[qon_q[tid_q]] == tid_q)
								tail_q[qon_q[tid_q]] <= prv_q[tid_q];
							else prv_q[nxt_q[tid_q]] <= prv_q[tid_q];
							cnt_q[qon_q[tid_q]] <= cnt_q[qon_q[tid_q]] - CW'(1);
							mode_q[tid_q] <= M_RUN;
							// append to run queue (never the same queue)
							if (cnt_q[RUNQ] != '0) begin
								nxt_q[tail_q[RUNQ]] <= tid_q;
								prv_q[tid_q] <= tail_q[RUNQ];
							end else head_q[RUNQ] <= tid_q;
							tail_q[RUNQ] <= tid_q;
							cnt_q[RUNQ] <= cnt_q[RUNQ] + CW'(1);
							qon_q[tid_q] <= RUNQ;
						end
					end
					A_EXIT: if (runv_q) begin
						mode_q[run_q] <= M_NONE;
						if (qon_q[run_q] < QW'(NQ) && cnt_q[qon_q[run_q]] != '0) begin
							if (head_q[qon_q[run_q]] == run_q)
								head_q[qon_q[run_q]] <= nxt_q[run_q];
							else nxt_q[prv_q[run_q]] <= nxt_q[run_q];
							if (tail_q[qon_q[run_q]] == run_q)
								tail_q[qon_q[run_q]] <= prv_q[run_q];
							else prv_q[nxt_q[run_q]] <= prv_q[run_q];
							cnt_q[qon_q[run_q]] <= cnt_q[qon_q[run_q]] - CW'(1);
							qon_q[run_q] <= QNONE;
						end
					end
					default: ;
				endcase
			end
			if (cmd.sw) begin
				// push current then pop head; fold the one-entry case
				if (push_cur) begin
					if (cnt_q[RUNQ] == '0) begin
						run_q <= run_q;
						runv_q <= 1'b1;
					end else begin
						nxt_q[tail_q[RUNQ]] <= run_q;
						prv_q[run_q] <= tail_q[RUNQ];
						tail_q[RUNQ] <= run_q;
						qon_q[run_q] <= RUNQ;
						run_q <= head_q[RUNQ];
						runv_q <= 1'b1;
						// single waiter: the pushed thread becomes the head
						head_q[RUNQ] <= (cnt_q[RUNQ] == CW'(1)) ? run_q
							: nxt_q[head_q[RUNQ]];
						qon_q[head_q[RUNQ]] <= QNONE;
					end
				end else if (cnt_q[RUNQ] != '0) begin
					run_q <= head_q[RUNQ];
					runv_q <= 1'b1;
					if (cnt_q[RUNQ] > CW'(1)) head_q[RUNQ] <= nxt_q[head_q[RUNQ]];
					cnt_q[RUNQ] <= cnt_q[RUNQ] - CW'(1);
					qon_q[head_q[RUNQ]] <= QNONE;
				end else begin
					run_q <= '0;
					runv_q <= 1'b0;
				end
			end
			if (cmd.step) begin
				bcn_q <= bcn_q + TW'(1);
				wk_q <= head_q[qa];
				if (cnt_q[qa] > CW'(1)) head_q[qa] <= nxt_q[head_q[qa]];
				cnt_q[qa] <= cnt_q[qa] - CW'(1);
				mode_q[head_q[qa]] <= M_RUN;
				if (cnt_q[RUNQ] != '0) begin
					nxt_q[tail_q[RUNQ]] <= head_q[qa];
					prv_q[head_q[qa]] <= tail_q[RUNQ];
				end else head_q[RUNQ] <= head_q[qa];
				tail_q[RUNQ] <= head_q[qa];
				cnt_q[RUNQ] <= cnt_q[RUNQ] + CW'(1);
				qon_q[head_q[qa]] <= RUNQ;
			end
		end
	end

	// Result fields; status/last latched at the emitting cycle.
	logic sw_idle;
	assign sw_idle = !push_cur && cnt_q[RUNQ] == '0;
	always_ff @(posedge clk) begin
		if (do_exec_q) begin
			st_q <= est;
			wkv_q <= ewv && early;
			last_q <= 1'b1;
		end
		if (cmd.sw) begin
			st_q <= sw_idle ? S_IDLE : S_OK;
			wkv_q <= 1'b0;
		end
		if (cmd.step) begin
			st_q <= S_OK;
			wkv_q <= 1'b1;
			last_q <= cmd.emit_last;
		end
	end

	assign status = st_q;
	assign woken_valid = wkv_q;
	assign woken_thread = wkv_q ? wk_q : '0;
	assign current_valid = runv_q;
	assign current_thread = runv_q ? run_q : '0;
	assign current_cancelled = runv_q && cflag_q[run_q];
	assign last = last_q;
endmodule
